// File: rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants of the segment hole allocator
// Operation, policy, status and CSR index codes, word types of the channels.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int ADDR_BITS = 16;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_INIT  = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;
   localparam logic [1:0] POL_RSVD  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_COMPACT = 2'd1;
   localparam logic [1:0] ST_NOMEM   = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [1:0] CSR_FIT_POLICY    = 2'd0;
   localparam logic [1:0] CSR_MEMORY_SIZE   = 2'd1;
   localparam logic [1:0] CSR_RESERVED_SIZE = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [16:0] req_size;
      logic [15:0] seg_base;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] alloc_base;
      logic [16:0] free_total;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [16:0] data;
   } csr_word_type;

endpackage

// File: rtl/core/sha_if.sv
// ----------------------------------------------------------------------------
// sha_if: valid/ready channel carrying one word of a given type
// ----------------------------------------------------------------------------
interface sha_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// File: rtl/core/sha_cell.sv
// ----------------------------------------------------------------------------
// sha_cell: one hole entry of the rotating hole table
// Each cycle the entry moves to the next cell; the head cell may rewrite it.
// ----------------------------------------------------------------------------
module sha_cell #(
   parameter int AW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clr,
   input  logic          in_valid,
   input  logic [AW-1:0] in_base,
   input  logic [AW:0]   in_limit,
   output logic          out_valid,
   output logic [AW-1:0] out_base,
   output logic [AW:0]   out_limit
);
   logic          valid_ff;
   logic [AW-1:0] base_ff;
   logic [AW:0]   limit_ff;

   always_ff @(posedge clock) begin
      if (reset || clr) begin
         valid_ff <= 1'b0;
         base_ff  <= '0;
         limit_ff <= '0;
      end else begin
         valid_ff <= in_valid;
         base_ff  <= in_base;
         limit_ff <= in_limit;
      end
   end

   assign out_valid = valid_ff;
   assign out_base  = base_ff;
   assign out_limit = limit_ff;
endmodule

// File: rtl/core/segment_hole_allocator_unit.sv
// ----------------------------------------------------------------------------
// segment_hole_allocator_unit: free-hole table of a segmented memory
// Allocate (first, best or worst fit), free with neighbor merge, initialize.
// ----------------------------------------------------------------------------
// Use: words enter on req (opcode, req_size, seg_base); one word per request
// leaves on rsp (status, alloc_base, free_total). csr writes fit_policy,
// memory_size and reserved_size; the user must write them only while the
// block is idle, which the block itself does not enforce. The holes sit in
// a ring of MAX_HOLES cells that rotates one place a cycle. Allocate and
// free work in two passes over the ring: a scan pass that finds the chosen
// hole, merge neighbors, free slot and overlap, then an update pass that
// rewrites entries as they pass the head cell; initialize skips the scan.
// free_total is kept as a running register updated at the end of each op.
// One request at a time; req is ready only when no request is in work.
// A stalled rsp holds its word in the output register; the next request is
// still taken and worked, then waits at its end until that word leaves.
// Reset empties the table and loads register defaults.
// ----------------------------------------------------------------------------
module segment_hole_allocator_unit #(
   parameter int MAX_HOLES = 32
) (
   input  logic clock,
   input  logic reset,
   sha_if.sink   req,
   sha_if.source rsp,
   sha_if.sink   csr
);
   import sha_pkg::*;

   localparam int AW = ADDR_BITS;
   localparam int CW = $clog2(MAX_HOLES);
   localparam logic [AW:0] SPAN = {1'b1, {AW{1'b0}}};

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]  pol_ff;
   logic [16:0] msz_ff, rsz_ff;
   req_word_type cmd_ff, cmd_in;
   rsp_word_type out_ff, out_in;
   rsp_word_type rsp_ff, rsp_in;
   logic        rv_ff, rv_in;
   logic [16:0] tot_ff, tot_in;

   // scan results, positions counted from head at scan start
   logic          pk_ff, pk_in;
   logic [CW-1:0] pki_ff, pki_in;
   logic [AW-1:0] pkb_ff, pkb_in;
   logic [AW:0]   pks_ff, pks_in;
   logic          pv_ff, pv_in, nx_ff, nx_in, sl_ff, sl_in, ov_ff, ov_in;
   logic [CW-1:0] pvi_ff, pvi_in, nxi_ff, nxi_in, sli_ff, sli_in;
   logic [AW-1:0] pvb_ff, pvb_in;
   logic [AW:0]   nxl_ff, nxl_in;

   logic          cv [MAX_HOLES];
   logic [AW-1:0] cb [MAX_HOLES];
   logic [AW:0]   cl [MAX_HOLES];
   logic          hv;
   logic [AW-1:0] hb;
   logic [AW:0]   hl;
   logic          clr;

   genvar g;
   generate
      for (g = 0; g < MAX_HOLES; g++) begin : g_cell
         if (g == MAX_HOLES - 1) begin : g_tail
            sha_cell #(.AW(AW)) u_cell (
               .clock, .reset, .clr,
               .in_valid(hv), .in_base(hb), .in_limit(hl),
               .out_valid(cv[g]), .out_base(cb[g]), .out_limit(cl[g]));
         end else begin : g_mid
            sha_cell #(.AW(AW)) u_cell (
               .clock, .reset, .clr,
               .in_valid(cv[g+1]), .in_base(cb[g+1]), .in_limit(cl[g+1]),
               .out_valid(cv[g]), .out_base(cb[g]), .out_limit(cl[g]));
         end
      end
   endgenerate

   logic [AW:0]   e_ext;
   logic [AW+1:0] e_wide;
   logic [AW:0]   hsz;
   logic [AW:0]   req_a;
   logic          fits, better;
   logic [AW:0]   lo, hi, nb_w, nl_w;
   logic [AW:0]   newb;
   logic          fr_bad;

   always_comb begin
      e_wide = (AW+2)'(cmd_ff.seg_base) + (AW+2)'(cmd_ff.req_size);
      e_ext  = e_wide[AW:0];
      fr_bad = (cmd_ff.req_size == '0) || (e_wide > (AW+2)'(SPAN));
      hsz    = cl[0] - {1'b0, cb[0]};
      req_a  = (AW+1)'(cmd_ff.req_size);
      fits   = cv[0] && (hsz >= req_a);
      if (!pk_ff) better = 1'b1;
      else case (pol_ff)
         POL_BEST:  better = hsz < pks_ff || (hsz == pks_ff && cb[0] < pkb_ff);
         POL_WORST: better = hsz > pks_ff || (hsz == pks_ff && cb[0] < pkb_ff);
         default:   better = cb[0] < pkb_ff;
      endcase
      lo = (rsz_ff > 17'(SPAN)) ? SPAN : (AW+1)'(rsz_ff);
      hi = (msz_ff > 17'(SPAN)) ? SPAN : (AW+1)'(msz_ff);
      nb_w = pv_ff ? {1'b0, pvb_ff} : {1'b0, cmd_ff.seg_base};
      nl_w = nx_ff ? nxl_ff : e_ext;
      newb = {1'b0, cb[0]} + req_a;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd_in = cmd_ff;
      out_in = out_ff;
      rsp_in = rsp_ff;
      rv_in = rv_ff;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      tot_in = tot_ff;
      pk_in = pk_ff; pki_in = pki_ff; pkb_in = pkb_ff; pks_in = pks_ff;
      pv_in = pv_ff; pvi_in = pvi_ff; pvb_in = pvb_ff;
      nx_in = nx_ff; nxi_in = nxi_ff; nxl_in = nxl_ff;
      sl_in = sl_ff; sli_in = sli_ff; ov_in = ov_ff;
      hv = cv[0]; hb = cb[0]; hl = cl[0];
      clr = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.word;
               cnt_in = '0;
               pk_in = 1'b0; pv_in = 1'b0; nx_in = 1'b0; sl_in = 1'b0; ov_in = 1'b0;
               if (req.word.opcode == OP_INIT) begin
                  clr = 1'b1;
                  state_in = S_UPD;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (cmd_ff.opcode == OP_ALLOC) begin
               if (fits && better) begin
                  pk_in = 1'b1; pki_in = cnt_ff; pkb_in = cb[0]; pks_in = hsz;
               end
            end else begin
               if (!cv[0]) begin
                  if (!sl_ff) begin sl_in = 1'b1; sli_in = cnt_ff; end
               end else begin
                  if ({1'b0, cb[0]} < e_ext && {1'b0, cmd_ff.seg_base} < cl[0])
                     ov_in = 1'b1;
                  if (cl[0] == {1'b0, cmd_ff.seg_base}) begin
                     pv_in = 1'b1; pvi_in = cnt_ff; pvb_in = cb[0];
                  end
                  if ({1'b0, cb[0]} == e_ext) begin
                     nx_in = 1'b1; nxi_in = cnt_ff; nxl_in = cl[0];
                  end
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAX_HOLES - 1)) begin
               cnt_in = '0;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            unique case (cmd_ff.opcode)
               OP_ALLOC: begin
                  if (pk_ff && cnt_ff == pki_ff) begin
                     hb = newb[AW-1:0];
                     if (newb == cl[0]) begin hv = 1'b0; hb = '0; hl = '0; end
                  end
               end
               OP_FREE: begin
                  if (!fr_bad && !ov_ff && (pv_ff || nx_ff || sl_ff)) begin
                     if (nx_ff && cnt_ff == nxi_ff) begin
                        hv = 1'b0; hb = '0; hl = '0;
                     end
                     if ((pv_ff && cnt_ff == pvi_ff) ||
                         (!pv_ff && nx_ff && cnt_ff == nxi_ff) ||
                         (!pv_ff && !nx_ff && cnt_ff == sli_ff)) begin
                        hv = 1'b1; hb = nb_w[AW-1:0]; hl = nl_w;
                     end
                  end
               end
               OP_INIT: begin
                  if (cnt_ff == CW'(MAX_HOLES - 1) && lo < hi) begin
                     hv = 1'b1; hb = lo[AW-1:0]; hl = hi;
                  end
               end
               default: ;
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAX_HOLES - 1)) begin
               state_in = S_OUT;
               out_in = '0;
               unique case (cmd_ff.opcode)
                  OP_ALLOC: begin
                     if (pk_ff) begin
                        out_in.alloc_base = 16'(pkb_ff);
                        tot_in = tot_ff - cmd_ff.req_size;
                     end else if (17'(tot_ff) >= cmd_ff.req_size) begin
                        out_in.status = ST_COMPACT;
                     end else begin
                        out_in.status = ST_NOMEM;
                     end
                  end
                  OP_FREE: begin
                     if (!fr_bad && !ov_ff) begin
                        if (pv_ff || nx_ff || sl_ff) tot_in = tot_ff + cmd_ff.req_size;
                        else out_in.status = ST_FULL;
                     end
                  end
                  OP_INIT: tot_in = (lo < hi) ? 17'(hi - lo) : '0;
                  default: ;
               endcase
               out_in.free_total = tot_in;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rsp_in = out_ff;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.word  = rsp_ff;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         tot_ff   <= '0;
         rv_ff    <= 1'b0;
         pol_ff   <= POL_FIRST;
         msz_ff   <= 17'd4096;
         rsz_ff   <= 17'd128;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         tot_ff   <= tot_in;
         rv_ff    <= rv_in;
         if (csr.valid) begin
            unique case (csr.word.index)
               CSR_FIT_POLICY:    pol_ff <= csr.word.data[1:0];
               CSR_MEMORY_SIZE:   msz_ff <= csr.word.data;
               CSR_RESERVED_SIZE: rsz_ff <= csr.word.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; out_ff <= out_in; rsp_ff <= rsp_in;
      pk_ff <= pk_in; pki_ff <= pki_in; pkb_ff <= pkb_in; pks_ff <= pks_in;
      pv_ff <= pv_in; pvi_ff <= pvi_in; pvb_ff <= pvb_in;
      nx_ff <= nx_in; nxi_ff <= nxi_in; nxl_ff <= nxl_in;
      sl_ff <= sl_in; sli_ff <= sli_in; ov_ff <= ov_in;
   end
endmodule
